### src/rgb565_to_bmp24_stream_macros.svh
// ---------------------------------------------------------------------------
// rgb565_to_bmp24_stream assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef RGB565_TO_BMP24_STREAM_MACROS_SVH
`define RGB565_TO_BMP24_STREAM_MACROS_SVH

// same-cycle implication, off during reset
`define R2B_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("r2b check failed");

// next-cycle implication, off during reset
`define R2B_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("r2b check failed");

// condition that must hold in the cycle after reset is applied
`define R2B_ASSERT_RST(lbl, post) \
  lbl: assert property (@(posedge clk) !rst_n |=> (post)) \
    else $error("r2b reset check failed");

`endif

### src/r2b_pkg.sv
// ---------------------------------------------------------------------------
// r2b_pkg
// Shared types, constants and the BMP header byte table.
// ---------------------------------------------------------------------------
package r2b_pkg;

  localparam int MAX_SIDE   = 4096;
  localparam int SIDE_W     = 13;   // width of a size register
  localparam int CNT_W      = 12;   // column and row counters
  localparam int SEQ_W      = 6;    // byte position inside one pixel's run
  localparam int IMG_W      = 27;   // row bytes times height

  localparam logic [1:0]       REG_WIDTH  = 2'd0;
  localparam logic [1:0]       REG_HEIGHT = 2'd1;

  localparam logic [SEQ_W-1:0] HDR_TOTAL  = 6'd54;
  localparam logic [SEQ_W-1:0] SEQ_BLUE   = 6'd54;
  localparam logic [SEQ_W-1:0] SEQ_GREEN  = 6'd55;
  localparam logic [SEQ_W-1:0] SEQ_RED    = 6'd56;
  localparam logic [31:0]      INFO_SIZE  = 32'd40;
  localparam logic [7:0]       BIT_COUNT  = 8'd24;

  typedef struct packed {
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
  } r2b_size_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       hdr;   // header goes out ahead of this pixel
    logic [1:0] pad;   // row padding bytes after this pixel
    logic       eof;   // last pixel of the frame
  } r2b_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } r2b_qstat_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] res;
    if (v == '0) res = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) res = SIDE_W'(MAX_SIDE);
    else res = v;
    return res;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [SEQ_W-1:0] idx,
                                          input logic [SIDE_W-1:0] w,
                                          input logic [SIDE_W-1:0] h,
                                          input logic [IMG_W-1:0]  img);
    logic [31:0] file_sz;
    logic [31:0] img_sz;
    logic [31:0] w32;
    logic [31:0] h32;
    logic [7:0]  res;
    file_sz = 32'(img) + 32'(HDR_TOTAL);
    img_sz  = 32'(img);
    w32     = 32'(w);
    h32     = 32'(h);
    unique case (idx)
      6'd0:    res = 8'h42;           // 'B'
      6'd1:    res = 8'h4D;           // 'M'
      6'd2:    res = file_sz[7:0];
      6'd3:    res = file_sz[15:8];
      6'd4:    res = file_sz[23:16];
      6'd5:    res = file_sz[31:24];
      6'd10:   res = 8'(HDR_TOTAL);
      6'd14:   res = INFO_SIZE[7:0];
      6'd18:   res = w32[7:0];
      6'd19:   res = w32[15:8];
      6'd22:   res = h32[7:0];
      6'd23:   res = h32[15:8];
      6'd26:   res = 8'd1;            // planes
      6'd28:   res = BIT_COUNT;
      6'd34:   res = img_sz[7:0];
      6'd35:   res = img_sz[15:8];
      6'd36:   res = img_sz[23:16];
      6'd37:   res = img_sz[31:24];
      default: res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

### src/rgb565_to_bmp24_stream.sv
// ---------------------------------------------------------------------------
// rgb565_to_bmp24_stream
// RGB565 pixel stream in, 24-bit BMP file byte stream out.
// ---------------------------------------------------------------------------
// Each pixel leaves as three bytes (B, G, R), one byte per cycle on the
// output register while out_tready is high; the output register holds its
// byte while out_tready is low. The 54-byte header goes out ahead of the
// first pixel of a frame, and (width mod 4) padding bytes follow the last
// pixel of a row. The byte sequencer in the back end walks these bytes; a
// two-entry command queue lets the input keep accepting pixels while it runs.
// out_tlast marks the last byte caused by each pixel, out_tuser the last byte
// of the file. Sizes of 0 count as 1 and sizes above 4096 as 4096.
module rgb565_to_bmp24_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // out_byte
  output logic        out_tlast,   // last_of_run
  output logic        out_tuser    // end_of_frame
);
  import r2b_pkg::*;

  logic [SIDE_W-1:0] width_r, width_nxt;
  logic [SIDE_W-1:0] height_r, height_nxt;
  r2b_size_t         size;
  r2b_cmd_t          wr_cmd, head;
  r2b_qstat_t        stat;
  logic              push, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  width_nxt  = cfg_data;
        REG_HEIGHT: height_nxt = cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_W'(320);
      height_r <= SIDE_W'(240);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign size.w = clamp_side(width_r);
  assign size.h = clamp_side(height_r);

  r2b_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .size      (size),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (stat.full),
    .push      (push),
    .cmd       (wr_cmd)
  );

  r2b_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .stat   (stat)
  );

  r2b_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .size       (size),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`include "rgb565_to_bmp24_stream_macros.svh"

  `R2B_ASSERT_IMPL(a_eof_is_last, out_tvalid && out_tuser, out_tlast)
  `R2B_ASSERT_IMPL(a_queue_state, 1'b1, !(stat.full && stat.empty))
  `R2B_ASSERT_NEXT(a_pop_not_empty, stat.empty, !pop)
  `R2B_ASSERT_RST(a_reset_idle, !out_tvalid && in_tready)

endmodule

### src/r2b_front.sv
// ---------------------------------------------------------------------------
// r2b_front
// Accepts pixels, expands them to B, G, R and tracks row and frame position.
// ---------------------------------------------------------------------------
module r2b_front (
  input  logic               clk,
  input  logic               rst_n,
  input  r2b_pkg::r2b_size_t size,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,
  input  logic               q_full,
  output logic               push,
  output r2b_pkg::r2b_cmd_t  cmd
);
  import r2b_pkg::*;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             hdr_done_r, hdr_done_nxt;
  logic             row_end;
  logic             frame_end;
  logic [4:0]       r5, b5;
  logic [5:0]       g6;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  assign r5 = in_tdata[15:11];
  assign g6 = in_tdata[10:5];
  assign b5 = in_tdata[4:0];

  assign row_end   = (SIDE_W'(col_r) + SIDE_W'(1)) >= size.w;
  assign frame_end = row_end && ((SIDE_W'(row_r) + SIDE_W'(1)) >= size.h);

  always_comb begin
    cmd.b   = {b5, b5[4:2]};
    cmd.g   = {g6, g6[5:4]};
    cmd.r   = {r5, r5[4:2]};
    cmd.hdr = !hdr_done_r;
    cmd.pad = row_end ? size.w[1:0] : 2'd0;   // padding of a 3w-byte row to a multiple of 4 equals w mod 4
    cmd.eof = frame_end;
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    hdr_done_nxt = hdr_done_r;
    if (push) begin
      hdr_done_nxt = !frame_end;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      hdr_done_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      hdr_done_r <= hdr_done_nxt;
    end
  end

endmodule

### src/r2b_queue.sv
// ---------------------------------------------------------------------------
// r2b_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module r2b_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  r2b_pkg::r2b_cmd_t  wr_cmd,
  input  logic               pop,
  output r2b_pkg::r2b_cmd_t  head,
  output r2b_pkg::r2b_qstat_t stat
);
  import r2b_pkg::*;

  r2b_cmd_t   mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rptr_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop  ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### src/r2b_back.sv
// ---------------------------------------------------------------------------
// r2b_back
// Walks each queued command byte by byte: header, pixel bytes, row padding.
// ---------------------------------------------------------------------------
module r2b_back (
  input  logic                clk,
  input  logic                rst_n,
  input  r2b_pkg::r2b_size_t  size,
  input  r2b_pkg::r2b_cmd_t   head,
  input  r2b_pkg::r2b_qstat_t stat,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // out_byte
  output logic                out_tlast,   // last_of_run
  output logic                out_tuser    // end_of_frame
);
  import r2b_pkg::*;

  logic [IMG_W-1:0] img_r;
  logic [13:0]      row_bytes;
  logic [14:0]      raw3;
  logic [SEQ_W-1:0] seq_r, seq_nxt, cur_seq, last_seq;
  logic             busy_r, busy_nxt;
  logic             load, last;
  logic [7:0]       byte_val;
  logic             vld_r, vld_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             tlast_r, tlast_nxt;
  logic             tuser_r, tuser_nxt;

  // image size from the current sizes; settles long before the header needs it
  assign raw3      = 15'(size.w) * 15'd3 + 15'd3;
  assign row_bytes = {raw3[13:2], 2'b00};

  always_ff @(posedge clk) begin
    img_r <= IMG_W'(row_bytes) * IMG_W'(size.h);
  end

  assign cur_seq  = busy_r ? seq_r : (head.hdr ? '0 : SEQ_BLUE);
  assign last_seq = SEQ_RED + SEQ_W'(head.pad);
  assign last     = cur_seq == last_seq;
  assign load     = !stat.empty && (!vld_r || out_tready);
  assign pop      = load && last;

  always_comb begin
    if (cur_seq < HDR_TOTAL)       byte_val = hdr_byte(cur_seq, size.w, size.h, img_r);
    else if (cur_seq == SEQ_BLUE)  byte_val = head.b;
    else if (cur_seq == SEQ_GREEN) byte_val = head.g;
    else if (cur_seq == SEQ_RED)   byte_val = head.r;
    else                           byte_val = 8'd0;
  end

  always_comb begin
    seq_nxt   = seq_r;
    busy_nxt  = busy_r;
    vld_nxt   = vld_r && !out_tready;
    data_nxt  = data_r;
    tlast_nxt = tlast_r;
    tuser_nxt = tuser_r;
    if (load) begin
      vld_nxt   = 1'b1;
      data_nxt  = byte_val;
      tlast_nxt = last;
      tuser_nxt = last && head.eof;
      busy_nxt  = !last;
      seq_nxt   = cur_seq + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r   <= seq_nxt;
    data_r  <= data_nxt;
    tlast_r <= tlast_nxt;
    tuser_r <= tuser_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = tlast_r;
  assign out_tuser  = tuser_r;

endmodule
